@@ hw/rtl/time_to_sample_table_macros.svh @@
// assertion macros for the time-to-sample table
`ifndef TIME_TO_SAMPLE_TABLE_MACROS_SVH
`define TIME_TO_SAMPLE_TABLE_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("time_to_sample_table assertion failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("time_to_sample_table assertion failed");

`endif

@@ hw/rtl/tts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes of the time-to-sample table.
// ----------------------------------------------------------------------------
package tts_pkg;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_APPEND = 3'd0;
    localparam t_opcode OP_T2S    = 3'd1;
    localparam t_opcode OP_S2T    = 3'd2;
    localparam t_opcode OP_SEED   = 3'd3;
    localparam t_opcode OP_LOAD   = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_PAST_END = 2'd2;
    localparam t_status ST_EMPTY    = 2'd3;

    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_UPDATE,
        RES_EMPTY,
        RES_PAST,
        RES_T2S,
        RES_S2T
    } t_res;

    typedef struct packed {
        logic capture;
        logic update;
        logic walk_init;
        logic mem_rd;
        logic mul_entry;
        logic accum;
        logic div_init;
        logic div_step;
        logic mul_tail;
        logic emit;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic op_t2s;
        logic op_s2t;
        logic empty;
        logic walk_end;
        logic hit;
        logic zero_dur;
        logic div_done;
    } t_sts;

endpackage

@@ hw/rtl/time_to_sample_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_to_sample_table
// Run-length (sample count, duration) table with time/sample lookups.
// ----------------------------------------------------------------------------
// Input channel: i_valid with the opcode and operand fields; the block
// raises o_stall while it works on a beat. Output channel: o_valid with
// the result fields; the receiver holds it with i_stall.
// Table updates (append, seed, load, unknown codes) go from accept through
// dispatch to the output state. Queries walk the stored runs, at most
// TABLE_DEPTH of them, each by read, multiply, accumulate and next, through
// the single table read port and the shared 32x32 multiplier; time to
// sample ends in a division within the run that was hit, one quotient bit
// per cycle, and sample to time in a multiply and add of that run's tail.
// One beat is in flight at a time; the next beat is taken once the current
// one has been moved to the output register, even if the receiver stalls.
// A stalled result holds until taken, and the block waits to deliver the
// next one. Synchronous reset empties the table at once, with no clearing
// pass; stored entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module time_to_sample_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_duration,
    input  logic [31:0] i_run_count,
    input  logic [62:0] i_query_time,
    input  logic [31:0] i_query_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_number,
    output logic [62:0] o_sample_time,
    output logic [8:0]  o_entry_total,
    output logic [39:0] o_sample_total,
    output logic [1:0]  o_status
);

    tts_pkg::t_cmd cmd;
    tts_pkg::t_sts sts;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    tts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_duration      (i_duration),
        .i_run_count     (i_run_count),
        .i_query_time    (i_query_time),
        .i_query_sample  (i_query_sample),
        .o_sample_number (o_sample_number),
        .o_sample_time   (o_sample_time),
        .o_entry_total   (o_entry_total),
        .o_sample_total  (o_sample_total),
        .o_status        (o_status)
    );

endmodule

@@ hw/rtl/tts_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_dp
// Table memory, run walk accumulators, shared multiplier and divider.
// ----------------------------------------------------------------------------
module tts_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tts_pkg::t_cmd       i_cmd,
    output tts_pkg::t_sts       o_sts,
    input  logic [2:0]          i_opcode,
    input  logic [31:0]         i_duration,
    input  logic [31:0]         i_run_count,
    input  logic [62:0]         i_query_time,
    input  logic [31:0]         i_query_sample,
    output logic [31:0]         o_sample_number,
    output logic [62:0]         o_sample_time,
    output logic [8:0]          o_entry_total,
    output logic [39:0]         o_sample_total,
    output logic [1:0]          o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = 32 + EW;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    logic [63:0] mem [TABLE_DEPTH];

    logic [2:0]  r_op;
    logic [31:0] r_dur;
    logic [31:0] r_cnt;
    logic [62:0] r_qt;
    logic [31:0] r_qs;

    logic [EW-1:0] r_entries;
    logic [39:0]   r_sum;
    logic [31:0]   r_last_cnt;
    logic [31:0]   r_last_dur;

    logic [EW-1:0] r_idx;
    logic [63:0]   r_rdata;
    logic [63:0]   r_prod;
    logic [62:0]   r_cur;
    logic [SW-1:0] r_seen;
    logic [31:0]   r_acc_idx;
    logic          r_hit;
    logic [31:0]   r_rem;
    logic [31:0]   r_dq;
    logic [5:0]    r_div_cnt;

    logic [31:0]   r_snum;
    logic [62:0]   r_stime;
    logic [1:0]    r_status;

    logic          upd_we;
    logic [EW-1:0] upd_addr;
    logic [31:0]   upd_cnt;
    logic [31:0]   upd_dur;
    logic [EW-1:0] n_entries;
    logic [39:0]   n_sum;
    logic          upd_full;

    logic [31:0]   rd_cnt;
    logic [31:0]   rd_dur;
    logic [62:0]   t_end;
    logic [SW-1:0] endc;
    logic [62:0]   div_num;
    logic [32:0]   div_t;
    logic          div_ge;
    logic [31:0]   tail_k;
    logic [31:0]   mul_a;

    function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, MAX63}) ? MAX63 : s[62:0];
    endfunction

    assign rd_cnt  = r_rdata[63:32];
    assign rd_dur  = r_rdata[31:0];
    assign t_end   = sat_add(r_cur, r_prod);
    assign endc    = r_seen + SW'(rd_cnt);
    assign div_num = r_qt - r_cur;
    assign div_t   = {r_rem, r_dq[31]};
    assign div_ge  = div_t >= {1'b0, rd_dur};
    assign tail_k  = 32'(SW'(r_qs) - r_seen);
    assign mul_a   = i_cmd.mul_tail ? tail_k : rd_cnt;

    always_comb begin
        upd_we    = 1'b0;
        upd_addr  = r_entries;
        upd_cnt   = 32'd1;
        upd_dur   = r_dur;
        n_entries = r_entries;
        n_sum     = r_sum;
        upd_full  = 1'b0;
        case (r_op)
            tts_pkg::OP_APPEND: begin
                if (r_entries != '0 && r_last_cnt == 32'd0) begin
                    upd_we   = 1'b1;
                    upd_addr = r_entries - EW'(1);
                    n_sum    = r_sum + 40'd1;
                end else if (r_entries != '0 && r_last_dur == r_dur
                             && r_last_cnt != 32'hFFFF_FFFF) begin
                    upd_we   = 1'b1;
                    upd_addr = r_entries - EW'(1);
                    upd_cnt  = r_last_cnt + 32'd1;
                    n_sum    = r_sum + 40'd1;
                end else if (r_entries == EW'(TABLE_DEPTH)) begin
                    upd_full = 1'b1;
                end else begin
                    upd_we    = 1'b1;
                    n_entries = r_entries + EW'(1);
                    n_sum     = r_sum + 40'd1;
                end
            end
            tts_pkg::OP_LOAD: begin
                upd_cnt = r_cnt;
                if (r_entries == EW'(TABLE_DEPTH)) begin
                    upd_full = 1'b1;
                end else begin
                    upd_we    = 1'b1;
                    n_entries = r_entries + EW'(1);
                    n_sum     = r_sum + 40'(r_cnt);
                end
            end
            tts_pkg::OP_SEED: begin
                upd_we    = 1'b1;
                upd_addr  = '0;
                upd_cnt   = 32'd0;
                n_entries = EW'(1);
                n_sum     = 40'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && upd_we) begin
            mem[upd_addr[AW-1:0]] <= {upd_cnt, upd_dur};
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_sum     <= '0;
        end else if (i_cmd.update) begin
            r_entries <= n_entries;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_dur <= i_duration;
            r_cnt <= i_run_count;
            r_qt  <= i_query_time;
            r_qs  <= i_query_sample;
        end
        if (i_cmd.update && upd_we) begin
            r_last_cnt <= upd_cnt;
            r_last_dur <= upd_dur;
        end
        if (i_cmd.walk_init) begin
            r_idx     <= '0;
            r_cur     <= '0;
            r_seen    <= '0;
            r_acc_idx <= '0;
            r_hit     <= 1'b0;
        end
        if (i_cmd.mul_entry || i_cmd.mul_tail) begin
            r_prod <= 64'(mul_a) * 64'(rd_dur);
        end
        if (i_cmd.accum) begin
            if (r_op == tts_pkg::OP_T2S) begin
                if (t_end > r_qt) begin
                    r_hit <= 1'b1;
                end else begin
                    r_cur     <= t_end;
                    r_acc_idx <= r_acc_idx + rd_cnt;
                    r_idx     <= r_idx + EW'(1);
                end
            end else begin
                if (endc > SW'(r_qs)) begin
                    r_hit <= 1'b1;
                end else begin
                    r_seen <= endc;
                    r_cur  <= t_end;
                    r_idx  <= r_idx + EW'(1);
                end
            end
        end
        if (i_cmd.div_init) begin
            r_rem     <= {1'b0, div_num[62:32]};
            r_dq      <= div_num[31:0];
            r_div_cnt <= 6'(tts_pkg::DIV_STEPS);
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? 32'(div_t - {1'b0, rd_dur}) : div_t[31:0];
            r_dq      <= {r_dq[30:0], div_ge};
            r_div_cnt <= r_div_cnt - 6'd1;
        end
        case (i_cmd.res)
            tts_pkg::RES_UPDATE: begin
                r_snum   <= '0;
                r_stime  <= '0;
                r_status <= upd_full ? tts_pkg::ST_FULL : tts_pkg::ST_OK;
            end
            tts_pkg::RES_EMPTY: begin
                r_snum   <= (r_op == tts_pkg::OP_S2T) ? r_qs : 32'd0;
                r_stime  <= '0;
                r_status <= tts_pkg::ST_EMPTY;
            end
            tts_pkg::RES_PAST: begin
                r_snum   <= (r_op == tts_pkg::OP_S2T) ? r_qs : 32'(r_entries - EW'(1));
                r_stime  <= (r_op == tts_pkg::OP_S2T) ? r_cur : r_qt;
                r_status <= tts_pkg::ST_PAST_END;
            end
            tts_pkg::RES_T2S: begin
                r_snum   <= r_acc_idx + r_dq;
                r_stime  <= r_qt - 63'(r_rem);
                r_status <= tts_pkg::ST_OK;
            end
            tts_pkg::RES_S2T: begin
                r_snum   <= r_qs;
                r_stime  <= t_end;
                r_status <= tts_pkg::ST_OK;
            end
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            o_sample_number <= r_snum;
            o_sample_time   <= r_stime;
            o_entry_total   <= 9'(r_entries);
            o_sample_total  <= r_sum;
            o_status        <= r_status;
        end
    end

    assign o_sts.op_t2s   = (r_op == tts_pkg::OP_T2S);
    assign o_sts.op_s2t   = (r_op == tts_pkg::OP_S2T);
    assign o_sts.empty    = (r_entries == '0);
    assign o_sts.walk_end = (r_idx == r_entries);
    assign o_sts.hit      = r_hit;
    assign o_sts.zero_dur = (rd_dur == 32'd0);
    assign o_sts.div_done = (r_div_cnt == 6'd0);

endmodule

@@ hw/rtl/tts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer for table updates, run walks, division and result handoff.
// ----------------------------------------------------------------------------
module tts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  tts_pkg::t_sts i_sts,
    output tts_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_MULT,
        S_ACCUM,
        S_NEXT,
        S_DIV,
        S_TAIL,
        S_TAIL_ADD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op_t2s || i_sts.op_s2t) begin
                    if (i_sts.empty) begin
                        o_cmd.res = tts_pkg::RES_EMPTY;
                        n_state   = S_OUT;
                    end else begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_READ;
                    end
                end else begin
                    o_cmd.update = 1'b1;
                    o_cmd.res    = tts_pkg::RES_UPDATE;
                    n_state      = S_OUT;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_MULT;
            end
            S_MULT: begin
                o_cmd.mul_entry = 1'b1;
                n_state         = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.hit) begin
                    if (i_sts.op_s2t) begin
                        n_state = S_TAIL;
                    end else if (i_sts.zero_dur) begin
                        o_cmd.res = tts_pkg::RES_PAST;
                        n_state   = S_OUT;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end
                end else if (i_sts.walk_end) begin
                    o_cmd.res = tts_pkg::RES_PAST;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.res = tts_pkg::RES_T2S;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_TAIL: begin
                o_cmd.mul_tail = 1'b1;
                n_state        = S_TAIL_ADD;
            end
            S_TAIL_ADD: begin
                o_cmd.res = tts_pkg::RES_S2T;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ hw/rtl/tts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the time-to-sample table, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_to_sample_table_macros.svh"

module tts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [62:0] o_sample_time,
    input logic [8:0]  o_entry_total,
    input logic [39:0] o_sample_total,
    input logic [1:0]  o_status
);

    logic empty_seen;
    logic empty_clean;

    assign empty_seen  = o_valid && (o_status == tts_pkg::ST_EMPTY);
    assign empty_clean = (o_entry_total == 9'd0) && (o_sample_time == 63'd0);

    `TTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `TTS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_sample_total))
    `TTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `TTS_ASSERT_SAME(a_empty_result, i_clk, i_rst_n, empty_seen, empty_clean)

endmodule

bind time_to_sample_table tts_checker u_tts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sample_time  (o_sample_time),
    .o_entry_total  (o_entry_total),
    .o_sample_total (o_sample_total),
    .o_status       (o_status)
);
